// File: rtl/core/slt_pkg.sv
// ----------------------------------------------------------------------------
// slt_pkg
// Shared constants, codes and types for the sorted list table core.
// ----------------------------------------------------------------------------
package slt_pkg;

   // store geometry
   localparam int CAPACITY = 64;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   // fixed field widths of the request and response
   localparam int FUNC_W   = 2;
   localparam int DATA_W   = 8;
   localparam int START_W  = 6;
   localparam int DCNT_W   = 7;
   localparam int STAT_W   = 2;
   localparam int LEN_W    = 7;

   // width that holds a start position plus a run length without overflow
   localparam int SUM_W    = ((CNT_W > DCNT_W) ? CNT_W : DCNT_W) + 1;

   // command codes
   localparam logic [FUNC_W-1:0] FN_INSERT = 2'd0;
   localparam logic [FUNC_W-1:0] FN_DELETE = 2'd1;
   localparam logic [FUNC_W-1:0] FN_LOCATE = 2'd2;
   localparam logic [FUNC_W-1:0] FN_NONE   = 2'd3;

   // status codes
   localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
   localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_EVAL
   } state_type;

   // store access issued by the sequencer
   typedef struct packed {
      logic              wr_en;
      logic [IDX_W-1:0]  wr_addr;
      logic [DATA_W-1:0] wr_data;
      logic              rd_en;
      logic [IDX_W-1:0]  rd_addr;
   } mem_req_type;

   // command completion
   typedef struct packed {
      logic              valid;
      logic [STAT_W-1:0] status;
      logic [CNT_W-1:0]  position;
      logic [CNT_W-1:0]  length;
   } fin_type;

endpackage

// File: rtl/core/slt_ram.sv
// ----------------------------------------------------------------------------
// slt_ram
// Entry store: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module slt_ram
   import slt_pkg::*;
(
   input  logic              clock,
   input  mem_req_type       mem_req,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [CAPACITY];
   logic [DATA_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem_ff[mem_req.wr_addr] <= mem_req.wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (mem_req.rd_en) begin
         rd_data_ff <= mem_ff[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/slt_ctrl.sv
// ----------------------------------------------------------------------------
// slt_ctrl
// Command sequencer: walks the store one entry per step (read and compare,
// and a write for insert and delete), shifting entries or searching for locate.
// ----------------------------------------------------------------------------
module slt_ctrl
   import slt_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [FUNC_W-1:0]  req_func,
   input  logic [DATA_W-1:0]  req_value,
   input  logic [START_W-1:0] req_start_index,
   input  logic [DCNT_W-1:0]  req_delete_count,
   input  logic [DATA_W-1:0]  rd_data,
   output logic               busy,
   output mem_req_type        mem_req,
   output fin_type            fin
);

   state_type         state_ff, state_in;
   logic [FUNC_W-1:0] func_ff, func_in;
   logic [DATA_W-1:0] value_ff, value_in;
   logic [DCNT_W-1:0] dcnt_ff, dcnt_in;
   logic [CNT_W-1:0]  pos_ff, pos_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   logic              accept;
   logic [SUM_W-1:0]  run_end;
   logic [SUM_W-1:0]  step_src;
   logic [CNT_W-1:0]  pos_dec;
   logic [CNT_W-1:0]  pos_inc;

   assign accept   = start && (state_ff == ST_IDLE);
   assign busy     = (state_ff != ST_IDLE);
   assign run_end  = SUM_W'(req_start_index) + SUM_W'(req_delete_count);
   assign step_src = SUM_W'(pos_ff) + SUM_W'(dcnt_ff);
   assign pos_dec  = pos_ff - CNT_W'(1);
   assign pos_inc  = pos_ff + CNT_W'(1);

   // state and working registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff  <= func_in;
      value_ff <= value_in;
      dcnt_ff  <= dcnt_in;
      pos_ff   <= pos_in;
   end

   // next state, store access and completion
   always_comb begin
      state_in        = state_ff;
      func_in         = func_ff;
      value_in        = value_ff;
      dcnt_in         = dcnt_ff;
      pos_in          = pos_ff;
      count_in        = count_ff;
      mem_req         = '0;
      fin             = '0;
      fin.length      = count_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               func_in  = req_func;
               value_in = req_value;
               dcnt_in  = req_delete_count;
               // checks that finish a request at once
               case (req_func)
                  FN_INSERT: begin
                     if (SUM_W'(count_ff) >= SUM_W'(CAPACITY)) begin
                        fin.valid  = 1'b1;
                        fin.status = STAT_FULL;
                     end else begin
                        pos_in   = count_ff;
                        state_in = ST_SCAN;
                     end
                  end
                  FN_DELETE: begin
                     if (run_end > SUM_W'(count_ff)) begin
                        fin.valid  = 1'b1;
                        fin.status = STAT_RANGE;
                     end else begin
                        pos_in   = CNT_W'(req_start_index);
                        state_in = ST_SCAN;
                     end
                  end
                  FN_LOCATE: begin
                     pos_in   = '0;
                     state_in = ST_SCAN;
                  end
                  default: begin
                     fin.valid = 1'b1;
                  end
               endcase
            end
         end

         ST_SCAN: begin
            case (func_ff)
               FN_INSERT: begin
                  // reached the bottom: new value goes first
                  if (pos_ff == '0) begin
                     mem_req.wr_en   = 1'b1;
                     mem_req.wr_addr = '0;
                     mem_req.wr_data = value_ff;
                     count_in        = count_ff + CNT_W'(1);
                     fin.valid       = 1'b1;
                     fin.length      = count_in;
                     state_in        = ST_IDLE;
                  end else begin
                     mem_req.rd_en   = 1'b1;
                     mem_req.rd_addr = pos_dec[IDX_W-1:0];
                     state_in        = ST_EVAL;
                  end
               end
               FN_DELETE: begin
                  if (step_src < SUM_W'(count_ff)) begin
                     mem_req.rd_en   = 1'b1;
                     mem_req.rd_addr = step_src[IDX_W-1:0];
                     state_in        = ST_EVAL;
                  end else begin
                     count_in   = count_ff - CNT_W'(dcnt_ff);
                     fin.valid  = 1'b1;
                     fin.length = count_in;
                     state_in   = ST_IDLE;
                  end
               end
               default: begin
                  // locate
                  if (pos_ff < count_ff) begin
                     mem_req.rd_en   = 1'b1;
                     mem_req.rd_addr = pos_ff[IDX_W-1:0];
                     state_in        = ST_EVAL;
                  end else begin
                     fin.valid = 1'b1;
                     state_in  = ST_IDLE;
                  end
               end
            endcase
         end

         ST_EVAL: begin
            case (func_ff)
               FN_INSERT: begin
                  mem_req.wr_en   = 1'b1;
                  mem_req.wr_addr = pos_ff[IDX_W-1:0];
                  // larger entry moves up one place, else the value lands here
                  if (rd_data > value_ff) begin
                     mem_req.wr_data = rd_data;
                     pos_in          = pos_dec;
                     state_in        = ST_SCAN;
                  end else begin
                     mem_req.wr_data = value_ff;
                     count_in        = count_ff + CNT_W'(1);
                     fin.valid       = 1'b1;
                     fin.length      = count_in;
                     state_in        = ST_IDLE;
                  end
               end
               FN_DELETE: begin
                  mem_req.wr_en   = 1'b1;
                  mem_req.wr_addr = pos_ff[IDX_W-1:0];
                  mem_req.wr_data = rd_data;
                  pos_in          = pos_inc;
                  state_in        = ST_SCAN;
               end
               default: begin
                  if (rd_data == value_ff) begin
                     fin.valid    = 1'b1;
                     fin.position = pos_inc;
                     state_in     = ST_IDLE;
                  end else begin
                     pos_in   = pos_inc;
                     state_in = ST_SCAN;
                  end
               end
            endcase
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// File: rtl/core/sorted_list_table_core.sv
// ----------------------------------------------------------------------------
// sorted_list_table_core
// Ascending list of byte values with insert, run delete and locate commands.
//
//   channel   | ports                                      | handshake
//   ----------+--------------------------------------------+------------------
//   request   | req_func req_value req_start_index         | start && !busy
//             | req_delete_count                           |
//   response  | rsp_status rsp_position rsp_list_length    | rsp_valid, 1 cycle
//
// One step is a store read followed by a compare and, for insert and delete,
// a store write; an insert at the front and a locate miss visit the most
// entries. Full inserts, infeasible deletes and the unused code answer at
// once. busy is high while a request is in work; the response strobe is
// registered and follows in the cycle after the request finishes. Reset
// empties the list; no response stall.
// ----------------------------------------------------------------------------
module sorted_list_table_core
   import slt_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [FUNC_W-1:0]  req_func,
   input  logic [DATA_W-1:0]  req_value,
   input  logic [START_W-1:0] req_start_index,
   input  logic [DCNT_W-1:0]  req_delete_count,
   output logic               rsp_valid,
   output logic [STAT_W-1:0]  rsp_status,
   output logic [LEN_W-1:0]   rsp_position,
   output logic [LEN_W-1:0]   rsp_list_length
);

   mem_req_type       mem_req;
   fin_type           fin;
   logic [DATA_W-1:0] rd_data;

   logic              rsp_valid_ff;
   logic [STAT_W-1:0] rsp_status_ff;
   logic [LEN_W-1:0]  rsp_position_ff;
   logic [LEN_W-1:0]  rsp_length_ff;

   slt_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .req_func         (req_func),
      .req_value        (req_value),
      .req_start_index  (req_start_index),
      .req_delete_count (req_delete_count),
      .rd_data          (rd_data),
      .busy             (busy),
      .mem_req          (mem_req),
      .fin              (fin)
   );

   slt_ram u_ram (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= fin.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (fin.valid) begin
         rsp_status_ff   <= fin.status;
         rsp_position_ff <= LEN_W'(fin.position);
         rsp_length_ff   <= LEN_W'(fin.length);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_position    = rsp_position_ff;
   assign rsp_list_length = rsp_length_ff;

   // an accepted request is either in work or answered next cycle
   a_accept_progress : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_valid))
      else $error("accepted request neither in work nor answered");

   // a full insert only happens with the list at capacity
   a_full_length : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STAT_FULL) |->
         (rsp_list_length == LEN_W'(CAPACITY) && rsp_position == '0))
      else $error("full status with list below capacity");

   // a found position never lies beyond the list
   a_position_bound : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_position <= rsp_list_length))
      else $error("located position beyond list length");

   // a response strobe only follows a cycle of work or an accept
   a_no_spurious : assert property (@(posedge clock) disable iff (reset)
      (!busy && !start) |=> !rsp_valid)
      else $error("response without a request");

endmodule
